// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands sampled on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, expr) \
    `ASSERT_PROP(lbl, !(expr))

`endif

// ===== design/raes_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raes_pkg
// Shared widths, constants and control types of the readout argmax scorer.
// ---------------------------------------------------------------------------
package raes_pkg;

    localparam int CNT_W = 16;             // spike count
    localparam int EXP_W = 7;              // target group index
    localparam int RC_W  = 7;              // group count register
    localparam int IDX_W = 6;              // position inside a set
    localparam int TOT_W = 22;             // running total
    localparam int DEN_W = TOT_W + RC_W;   // divisor, total times length
    localparam int Q_W   = 17;             // Q1.16 quotient, 65536 = 1.0
    localparam int STEP_W = 5;

    localparam logic [RC_W-1:0]   MAX_READOUTS = 7'd64;
    localparam logic [RC_W-1:0]   RC_RESET     = 7'd4;
    localparam logic [RC_W-1:0]   MIN_VALID_N  = 7'd2;
    localparam logic [STEP_W-1:0] DIV_STEPS    = 5'd17;
    localparam logic [Q_W-1:0]    ONE_Q16      = 17'h10000;
    localparam logic [EXP_W-1:0]  NO_PATTERN   = 7'h7F;   // -1

    typedef struct packed {
        logic accept;      // take the presented item
        logic mult;        // form divisor and dividend
        logic div_step;    // one restoring division step
        logic load;        // move result into output register
    } raes_cmd_t;

    typedef struct packed {
        logic last;        // presented item closes the set
    } raes_status_t;

endpackage

// ===== design/raes_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raes_datapath
// Set accumulators, divisor multiply, serial divider and output register.
// ---------------------------------------------------------------------------
module raes_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [raes_pkg::RC_W-1:0]           cfg_write_data,
    input  logic signed [raes_pkg::CNT_W-1:0]   spike_count,
    input  logic [raes_pkg::EXP_W-1:0]          target_group,
    input  raes_pkg::raes_cmd_t                 cmd,
    output raes_pkg::raes_status_t              status,
    output logic                                ok,
    output logic signed [raes_pkg::EXP_W-1:0]   winner_group,
    output logic [raes_pkg::Q_W-1:0]            mean_abs_error,
    output logic [raes_pkg::Q_W-1:0]            score
);

    localparam int CNT_W = raes_pkg::CNT_W;
    localparam int EXP_W = raes_pkg::EXP_W;
    localparam int RC_W  = raes_pkg::RC_W;
    localparam int IDX_W = raes_pkg::IDX_W;
    localparam int TOT_W = raes_pkg::TOT_W;
    localparam int DEN_W = raes_pkg::DEN_W;
    localparam int Q_W   = raes_pkg::Q_W;

    // set state
    logic [RC_W-1:0]         group_count_reg;
    logic [IDX_W-1:0]        item_index_reg, item_index_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic signed [CNT_W-1:0] max_count_reg, max_count_next;
    logic [EXP_W-1:0]        max_index_reg, max_index_next;
    logic [EXP_W-1:0]        exp_index_reg, exp_index_next;
    logic [CNT_W-1:0]        exp_count_reg, exp_count_next;
    logic                    invalid_reg, invalid_next;

    // division operands and results
    logic                    fin_ok_reg;
    logic                    fin_zero_reg;
    logic [EXP_W-1:0]        fin_recalled_reg;
    logic [TOT_W-1:0]        fin_total_reg;
    logic [TOT_W-1:0]        fin_diff_reg;
    logic [RC_W-1:0]         fin_n_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [Q_W-1:0]          quo_reg;
    logic                    ok_reg;
    logic [EXP_W-1:0]        recalled_reg;
    logic [Q_W-1:0]          mae_reg;
    logic [Q_W-1:0]          score_reg;

    logic [RC_W-1:0]         n_eff;
    logic [EXP_W-1:0]        exp_cur;
    logic                    count_neg;
    logic                    is_last;
    logic                    is_new_max;
    logic                    is_expected;
    logic [TOT_W-1:0]        total_sum;
    logic [CNT_W-1:0]        exp_count_sum;
    logic [EXP_W-1:0]        max_index_sum;
    logic                    invalid_sum;
    logic [DEN_W-1:0]        product;
    logic [DEN_W:0]          rem_shift;
    logic                    rem_ge;

    // set length: saturate to the maximum, never below one
    always_comb
    begin
        if (group_count_reg > raes_pkg::MAX_READOUTS)
            n_eff = raes_pkg::MAX_READOUTS;
        else if (group_count_reg == '0)
            n_eff = RC_W'(1);
        else
            n_eff = group_count_reg;
    end

    always_comb
    begin
        exp_cur       = (item_index_reg == '0) ? target_group : exp_index_reg;
        count_neg     = spike_count[CNT_W-1];
        is_last       = (RC_W'({1'b0, item_index_reg}) + RC_W'(1)) >= n_eff;
        is_new_max    = !count_neg && (spike_count > max_count_reg);
        is_expected   = !count_neg && (EXP_W'({1'b0, item_index_reg}) == exp_cur);
        total_sum     = count_neg ? total_reg
                                  : total_reg + TOT_W'(unsigned'(spike_count));
        exp_count_sum = is_expected ? unsigned'(spike_count) : exp_count_reg;
        max_index_sum = is_new_max ? EXP_W'({1'b0, item_index_reg}) : max_index_reg;
        invalid_sum   = invalid_reg || count_neg;
        status.last   = is_last;
    end

    always_comb
    begin
        item_index_next = item_index_reg;
        total_next      = total_reg;
        max_count_next  = max_count_reg;
        max_index_next  = max_index_reg;
        exp_index_next  = exp_index_reg;
        exp_count_next  = exp_count_reg;
        invalid_next    = invalid_reg;
        if (cmd.accept)
        begin
            if (is_last)
            begin
                // clear for the next set
                item_index_next = '0;
                total_next      = '0;
                max_count_next  = '1;
                max_index_next  = '1;
                exp_index_next  = '0;
                exp_count_next  = '0;
                invalid_next    = 1'b0;
            end
            else
            begin
                item_index_next = item_index_reg + IDX_W'(1);
                total_next      = total_sum;
                max_count_next  = is_new_max ? spike_count : max_count_reg;
                max_index_next  = max_index_sum;
                exp_index_next  = exp_cur;
                exp_count_next  = exp_count_sum;
                invalid_next    = invalid_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= raes_pkg::RC_RESET;
            item_index_reg  <= '0;
            total_reg       <= '0;
            max_count_reg   <= '1;
            max_index_reg   <= '1;
            exp_index_reg   <= '0;
            exp_count_reg   <= '0;
            invalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                group_count_reg <= cfg_write_data;
            item_index_reg <= item_index_next;
            total_reg      <= total_next;
            max_count_reg  <= max_count_next;
            max_index_reg  <= max_index_next;
            exp_index_reg  <= exp_index_next;
            exp_count_reg  <= exp_count_next;
            invalid_reg    <= invalid_next;
        end
    end

    // divisor product, one multiply per set
    assign product = DEN_W'(fin_total_reg) * DEN_W'(fin_n_reg);

    // restoring step: remainder stays below the divisor
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_ge    = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_last)
        begin
            fin_ok_reg       <= !invalid_sum && (group_count_reg >= raes_pkg::MIN_VALID_N)
                                && (exp_cur < n_eff);
            fin_zero_reg     <= (total_sum == '0);
            fin_recalled_reg <= (total_sum == '0) ? raes_pkg::NO_PATTERN : max_index_sum;
            fin_total_reg    <= total_sum;
            fin_diff_reg     <= total_sum - TOT_W'(exp_count_sum);
            fin_n_reg        <= n_eff;
        end
        if (cmd.mult)
        begin
            // zero total: floor(65536 / N) as 1 * 2^17 / (2N)
            den_reg <= fin_zero_reg ? DEN_W'({fin_n_reg, 1'b0}) : product;
            rem_reg <= fin_zero_reg ? DEN_W'(1) : DEN_W'(fin_diff_reg);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? DEN_W'(rem_shift - {1'b0, den_reg}) : DEN_W'(rem_shift);
            quo_reg <= {quo_reg[Q_W-2:0], rem_ge};
        end
        if (cmd.load)
        begin
            ok_reg       <= fin_ok_reg;
            recalled_reg <= fin_ok_reg ? fin_recalled_reg : '0;
            mae_reg      <= fin_ok_reg ? quo_reg : '0;
            score_reg    <= fin_ok_reg ? raes_pkg::ONE_Q16 - quo_reg : '0;
        end
    end

    assign ok             = ok_reg;
    assign winner_group   = signed'(recalled_reg);
    assign mean_abs_error = mae_reg;
    assign score          = score_reg;

endmodule

// ===== design/raes_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raes_ctrl
// Sequencer: accumulate, multiply, divide, then hand off to the output.
// ---------------------------------------------------------------------------
module raes_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  raes_pkg::raes_status_t   status,
    output raes_pkg::raes_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_ACCUM  = 3'b001,
        S_MULT   = 3'b010,
        S_DIVIDE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [raes_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;

    always_comb
    begin
        // a closing item waits until the output register is free
        in_stall       = (state_reg != S_ACCUM) || (status.last && out_valid_reg);
        cmd            = '0;
        cmd.accept     = in_valid && !in_stall;
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_ACCUM:
            begin
                if (cmd.accept && status.last)
                    state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                step_next  = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (step_reg == raes_pkg::DIV_STEPS)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACCUM;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    step_next    = step_reg + raes_pkg::STEP_W'(1);
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/readout_argmax_error_scorer.sv =====
`timescale 1ns / 1ps
// Readout argmax and error scorer: how to use it.
// Input channel (in_valid / in_stall) carries one item per readout group:
// spike_count and, on the first item of a set, target_group. A set is
// group_count items long, saturated to 64 and never below one.
// Output channel (out_valid / out_stall) carries one item per set: ok,
// winner_group, mean_abs_error and score (Q1.16, 65536 = 1.0).
// Configuration: pulse cfg_write_en with cfg_write_data to set group_count;
// a new length takes effect with the next input item.
// Throughput: inside a set one item per cycle. The item closing a set
// starts the 17-step restoring divider; the result is formed by a
// multiply, the 17 division steps and an output load, and the input
// stalls until the output load is done.
// A closing item is also held off while the previous result is still
// waiting on a stalled receiver; non-closing items keep flowing.
// Reset: group_count returns to 4, the set state is cleared and no result
// is pending. A stalled result holds its fields until it is taken.
// ---------------------------------------------------------------------------
// readout_argmax_error_scorer
// Top level: controller and datapath of the readout scorer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module readout_argmax_error_scorer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [raes_pkg::RC_W-1:0]           cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [raes_pkg::CNT_W-1:0]   spike_count,
    input  logic [raes_pkg::EXP_W-1:0]          target_group,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ok,
    output logic signed [raes_pkg::EXP_W-1:0]   winner_group,
    output logic [raes_pkg::Q_W-1:0]            mean_abs_error,
    output logic [raes_pkg::Q_W-1:0]            score
);

    raes_pkg::raes_cmd_t    cmd;
    raes_pkg::raes_status_t status;

    // sequence the set end: multiply, divide, load
    raes_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // accumulate counts, divide, hold the result
    raes_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .spike_count      (spike_count),
        .target_group     (target_group),
        .cmd              (cmd),
        .status           (status),
        .ok               (ok),
        .winner_group     (winner_group),
        .mean_abs_error   (mean_abs_error),
        .score            (score)
    );

    // error and score always add up to one on a valid decode
    `ASSERT_PROP(a_score_sum, out_valid && ok |->
        ({1'b0, mean_abs_error} + {1'b0, score}) == {1'b0, raes_pkg::ONE_Q16})

    // an invalid decode carries zero fields
    `ASSERT_PROP(a_invalid_zero, out_valid && !ok |->
        (winner_group == '0 && mean_abs_error == '0 && score == '0))

    // a closing item is never taken over a pending result
    `ASSERT_NEVER(a_no_overrun, in_valid && !in_stall && status.last && out_valid)

    // control commands of the datapath are mutually exclusive
    `ASSERT_PROP(a_cmd_onehot, $onehot0({cmd.accept, cmd.mult, cmd.div_step, cmd.load}))

endmodule
